@@ hdl/uitf_pkg.sv @@
`timescale 1ns / 1ps

package uitf_pkg;

    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int STAMP_W   = 32;
    localparam int ERR_W     = 3;
    localparam int INDEX_W   = 8;
    localparam int LEN_W     = 9;
    localparam int THR_W     = 9;
    localparam int TIMEOUT_W = 16;
    localparam int SCALE_W   = 8;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [THR_W-1:0]     THR_RST     = THR_W'(128);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(20);
    localparam logic [SCALE_W-1:0]   SCALE_RST   = SCALE_W'(2);

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_SCALE     = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   rx_byte;
        logic [STAMP_W-1:0]  now_stamp;
        logic [ERR_W-1:0]    line_errors;
        logic [INDEX_W-1:0]  read_index;
    } item_t;

    typedef struct packed {
        logic                frame_done;
        logic [LEN_W-1:0]    frame_length;
        logic [ERR_W-1:0]    error_flags;
        logic [STAMP_W-1:0]  max_gap;
        logic [BYTE_W-1:0]   read_data;
        logic                receiving;
    } result_t;

endpackage

@@ hdl/uart_rx_idle_timeout_framer_top.sv @@
`timescale 1ns / 1ps

// UART receive framer with idle timeout.
// Item channel (item, item_valid, item_stall): one request per byte received,
// timer tick, frame restart or buffer read. Result channel (result,
// result_valid, result_stall): exactly one result per request, in order.
// A request is held in the input register, where the frame state is
// updated and the buffer read or written, and then lands in the result
// register, which drives result_valid. One request is taken every cycle
// while the result side keeps up.
// The buffer has one write and one read port; reads are issued from the
// incoming request on acceptance and a write on the same edge is forwarded.
// When result_stall is high the result is held and the input register
// fills; item_stall then rises until the result is taken.
// Reset clears the frame (no bytes, countdown and gap zero, accepting) and
// loads threshold 128, timeout 20 and gap scale 2. The buffer is not cleared:
// only positions below the current length are ever returned.
// Configuration is via the APB port (0x0 threshold, 0x4 timeout, 0x8 gap scale);
// the user ensures it is written while no request is in flight; nothing checks.
module uart_rx_idle_timeout_framer_top
    import uitf_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                clk,
    input  logic                rst_n,

    input  item_t               item,
    input  logic                item_valid,
    output logic                item_stall,

    output result_t             result,
    output logic                result_valid,
    input  logic                result_stall,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int AW  = (BUFFER_BYTES > 2) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CW  = $clog2(BUFFER_BYTES + 1);
    localparam int IW  = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int RCW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int TCW = (CW > THR_W) ? CW : THR_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(BUFFER_BYTES);

    // configuration
    logic [THR_W-1:0]     thr_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [SCALE_W-1:0]   scale_reg;
    reg_idx_t             cfg_idx;
    logic                 cfg_wr;

    // pipeline
    item_t        stage_reg;
    logic         stage_vld_reg;
    result_t      result_reg, result_next;
    logic         result_vld_reg;
    logic         out_free;
    logic         adv;
    logic         accept;

    // frame state
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [TIMEOUT_W-1:0] cd_reg, cd_next;
    logic [ERR_W-1:0]     err_reg, err_next;
    logic [STAMP_W-1:0]   gap_reg, gap_next;
    logic [STAMP_W-1:0]   prev_reg, prev_next;
    logic                 acc_reg, acc_next;
    logic                 done;

    // buffer
    logic [BYTE_W-1:0]  mem [BUFFER_BYTES];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [IW-1:0]      ridx_ext;
    logic [AW-1:0]      rd_addr;
    logic [STAMP_W-1:0] gap;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_THRESHOLD: prdata = PDATA_W'(thr_reg);
            REG_TIMEOUT:   prdata = PDATA_W'(timeout_reg);
            REG_SCALE:     prdata = PDATA_W'(scale_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THR_RST;
            timeout_reg <= TIMEOUT_RST;
            scale_reg   <= SCALE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_THRESHOLD: thr_reg     <= pwdata[THR_W-1:0];
                REG_TIMEOUT:   timeout_reg <= pwdata[TIMEOUT_W-1:0];
                REG_SCALE:     scale_reg   <= pwdata[SCALE_W-1:0];
                default:       ;
            endcase
        end
    end

    assign out_free     = !result_vld_reg || !result_stall;
    assign adv          = stage_vld_reg && out_free;
    assign item_stall   = stage_vld_reg && !out_free;
    assign accept       = item_valid && !item_stall;
    assign result       = result_reg;
    assign result_valid = result_vld_reg;

    assign gap = stage_reg.now_stamp - prev_reg;

    always_comb
    begin
        logic [STAMP_W-1:0] scaled;
        scaled      = gap * STAMP_W'(scale_reg);
        cnt_next    = cnt_reg;
        cd_next     = cd_reg;
        err_next    = err_reg;
        gap_next    = gap_reg;
        prev_next   = prev_reg;
        acc_next    = acc_reg;
        done        = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = cnt_reg[AW-1:0];
        result_next = '0;
        case (stage_reg.kind)
            KIND_BYTE:
            begin
                if (acc_reg)
                begin
                    if (cnt_reg < CNT_MAX)
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    cd_next   = timeout_reg;
                    prev_next = stage_reg.now_stamp;
                    // first byte of a frame has no gap to measure
                    if (cnt_next != CW'(1) && scaled > gap_reg)
                        gap_next = scaled;
                    if (TCW'(cnt_next) > TCW'(thr_reg))
                    begin
                        err_next = stage_reg.line_errors;
                        acc_next = 1'b0;
                        done     = 1'b1;
                    end
                end
            end
            KIND_TICK:
            begin
                if (cd_reg != '0)
                begin
                    cd_next = cd_reg - TIMEOUT_W'(1);
                    if (cd_reg == TIMEOUT_W'(1) && cnt_reg != '0)
                    begin
                        err_next = stage_reg.line_errors;
                        acc_next = 1'b0;
                        done     = 1'b1;
                    end
                end
            end
            KIND_RESTART:
            begin
                cnt_next = '0;
                cd_next  = '0;
                err_next = '0;
                gap_next = '0;
                acc_next = 1'b1;
            end
            default:
            begin
                if (RCW'(stage_reg.read_index) < RCW'(cnt_reg))
                    result_next.read_data = rd_data_reg;
            end
        endcase
        result_next.frame_done   = done;
        result_next.frame_length = LEN_W'(cnt_next);
        result_next.error_flags  = err_next;
        result_next.max_gap      = gap_next;
        result_next.receiving    = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg  <= 1'b0;
            result_vld_reg <= 1'b0;
            cnt_reg        <= '0;
            cd_reg         <= '0;
            err_reg        <= '0;
            gap_reg        <= '0;
            prev_reg       <= '0;
            acc_reg        <= 1'b1;
        end
        else
        begin
            if (accept)
                stage_vld_reg <= 1'b1;
            else if (adv)
                stage_vld_reg <= 1'b0;
            if (adv)
                result_vld_reg <= 1'b1;
            else if (!result_stall)
                result_vld_reg <= 1'b0;
            if (adv)
            begin
                cnt_reg  <= cnt_next;
                cd_reg   <= cd_next;
                err_reg  <= err_next;
                gap_reg  <= gap_next;
                prev_reg <= prev_next;
                acc_reg  <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= item;
        if (adv)
            result_reg <= result_next;
    end

    assign ridx_ext = IW'(item.read_index);
    assign rd_addr  = ridx_ext[AW-1:0];

    // read is issued on acceptance; a write landing on the same edge is forwarded
    always_ff @(posedge clk)
    begin
        if (adv && wr_en)
            mem[wr_addr] <= stage_reg.rx_byte;
        if (accept)
        begin
            if (adv && wr_en && wr_addr == rd_addr)
                rd_data_reg <= stage_reg.rx_byte;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/uitf_chk.sv @@
`timescale 1ns / 1ps

module uitf_chk
    import uitf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    item_valid,
    input  logic    item_stall,
    input  result_t result,
    input  logic    result_valid,
    input  logic    result_stall
);

    // a held result must not change underneath the receiver
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // input side only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stalled with empty result register");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |-> !result.receiving)
        else $error("frame end left acceptance on");

    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.read_data != '0 |-> result.frame_length != '0)
        else $error("read data returned from an empty frame");

    a_empty_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_length == '0 |-> result.max_gap == '0)
        else $error("gap reported for an empty frame");

endmodule

bind uart_rx_idle_timeout_framer_top uitf_chk u_uitf_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);

@@ bench/uart_rx_idle_timeout_framer_top_test.sv @@
`timescale 1ns / 1ps

module uart_rx_idle_timeout_framer_top_test;
    import uitf_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int WATCHDOG    = 1000;

    // Tracks the frame the block should be holding and the results it owes.
    class frame_tracker;
        logic [THR_W-1:0]     thr;
        logic [TIMEOUT_W-1:0] tmo;
        logic [SCALE_W-1:0]   scale;
        logic [BYTE_W-1:0]    store [STORE_DEPTH];
        bit                   written [STORE_DEPTH];
        int unsigned          count;
        logic [TIMEOUT_W-1:0] countdown;
        logic [ERR_W-1:0]     latched;
        logic [STAMP_W-1:0]   largest;
        logic [STAMP_W-1:0]   prev;
        bit                   accepting;
        result_t              due_results [$];
        int                   errors;

        function new();
            thr       = THR_RST;
            tmo       = TIMEOUT_RST;
            scale     = SCALE_RST;
            count     = 0;
            countdown = '0;
            latched   = '0;
            largest   = '0;
            prev      = '0;
            accepting = 1'b1;
            errors    = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_THRESHOLD: thr   = value[THR_W-1:0];
                REG_TIMEOUT:   tmo   = value[TIMEOUT_W-1:0];
                REG_SCALE:     scale = value[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_request(item_t it);
            result_t            r;
            logic [STAMP_W-1:0] gap;
            r = '0;
            case (it.kind)
                KIND_BYTE:
                begin
                    if (accepting)
                    begin
                        // once full, the byte is dropped but still timed
                        if (count < STORE_DEPTH)
                        begin
                            store[count]   = it.rx_byte;
                            written[count] = 1'b1;
                            count++;
                        end
                        countdown = tmo;
                        if (count == 1)
                        begin
                            prev = it.now_stamp;
                        end
                        else
                        begin
                            gap = (it.now_stamp - prev) * scale;
                            if (gap > largest)
                                largest = gap;
                            prev = it.now_stamp;
                        end
                        if (count > thr)
                        begin
                            latched      = it.line_errors;
                            accepting    = 1'b0;
                            r.frame_done = 1'b1;
                        end
                    end
                end
                KIND_TICK:
                begin
                    if (countdown != 0)
                    begin
                        countdown--;
                        if (countdown == 0 && count > 0)
                        begin
                            latched      = it.line_errors;
                            accepting    = 1'b0;
                            r.frame_done = 1'b1;
                        end
                    end
                end
                KIND_RESTART:
                begin
                    count     = 0;
                    countdown = '0;
                    latched   = '0;
                    largest   = '0;
                    accepting = 1'b1;
                end
                default:
                begin
                    if (it.read_index < count)
                        r.read_data = store[it.read_index];
                end
            endcase
            r.frame_length = LEN_W'(count);
            r.error_flags  = latched;
            r.max_gap      = largest;
            r.receiving    = accepting;
            due_results.push_back(r);
        endfunction

        function void compare(string name, logic [STAMP_W-1:0] want, logic [STAMP_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare("frame_done", want.frame_done, got.frame_done);
            compare("frame_length", want.frame_length, got.frame_length);
            compare("error_flags", want.error_flags, got.error_flags);
            compare("max_gap", want.max_gap, got.max_gap);
            compare("read_data", want.read_data, got.read_data);
            compare("receiving", want.receiving, got.receiving);
        endfunction
    endclass

    logic               clk;
    logic               rst_n        = 1'b0;
    item_t              item         = '0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    result_t            result;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [PDATA_W-1:0] pwdata       = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    frame_tracker tracker = new();
    bit           calm    = 1'b0;
    int unsigned  sent    = 0;

    uart_rx_idle_timeout_framer_top #(
        .BUFFER_BYTES(STORE_DEPTH)
    ) u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random stall before each result, none while calm
    initial
    begin
        int n;
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.match_result(result);
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
                idle = 0;
            else
                idle++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic item_t rand_item(kind_t k);
        item_t it;
        it.kind        = k;
        it.rx_byte     = BYTE_W'($urandom);
        it.now_stamp   = $urandom;
        it.line_errors = ERR_W'($urandom);
        it.read_index  = INDEX_W'($urandom);
        if (k == KIND_BYTE && $urandom_range(0, 3) != 0)
            it.now_stamp = tracker.prev + $urandom_range(0, 2000);
        if (k == KIND_READ)
        begin
            if (tracker.count > 0 && $urandom_range(0, 1) == 0)
                it.read_index = INDEX_W'($urandom_range(0, tracker.count - 1));
            // never address a buffer slot that has not been written yet
            for (int t = 0; t < 16 && !tracker.written[it.read_index]; t++)
                it.read_index = INDEX_W'($urandom);
            if (!tracker.written[it.read_index])
                it.kind = KIND_TICK;
        end
        return it;
    endfunction

    task automatic send(item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sent++;
        tracker.take_request(it);
    endtask

    task automatic send_exact(kind_t k, logic [BYTE_W-1:0] b, logic [STAMP_W-1:0] st,
                              logic [ERR_W-1:0] er, logic [INDEX_W-1:0] idx);
        send({k, b, st, er, idx});
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task automatic configure(int unsigned thr, int unsigned tmo, int unsigned sc);
        wait_drained();
        apb_write(REG_THRESHOLD, thr);
        apb_write(REG_TIMEOUT, tmo);
        apb_write(REG_SCALE, sc);
    endtask

    // Mostly whole frames: a restart in most, bytes with the odd tick, reads, then
    // ticks towards the timeout and more reads. One pass in ten is a request of any kind.
    task automatic run_frames(int unsigned quota, int unsigned max_len);
        int unsigned target;
        int unsigned tick_cap;
        target = sent + quota;
        while (sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send(rand_item(kind_t'($urandom_range(0, 3))));
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    send(rand_item(KIND_RESTART));
                repeat ($urandom_range(1, max_len))
                begin
                    send(rand_item(KIND_BYTE));
                    if ($urandom_range(0, 4) == 0)
                        send(rand_item(KIND_TICK));
                end
                repeat ($urandom_range(0, 3)) send(rand_item(KIND_READ));
                tick_cap = (tracker.tmo > 8) ? 8 : tracker.tmo + 1;
                repeat ($urandom_range(0, tick_cap)) send(rand_item(KIND_TICK));
                repeat ($urandom_range(0, 2)) send(rand_item(KIND_READ));
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        run_frames(50, 12);

        configure(2, 3, 255);
        send_exact(KIND_RESTART, 8'h00, 32'h0, 3'd0, 8'd0);
        send_exact(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'hFF);   // countdown idle
        send_exact(KIND_BYTE, 8'h00, 32'hFFFF_FFF0, 3'd0, 8'd0);    // first byte, no gap
        send_exact(KIND_BYTE, 8'hFF, 32'h0000_0010, 3'd7, 8'd0);    // stamp wraps
        send_exact(KIND_READ, 8'h00, 32'h0, 3'd0, 8'd0);
        send_exact(KIND_READ, 8'h00, 32'h0, 3'd0, 8'd1);
        send_exact(KIND_BYTE, 8'hA5, 32'h0000_000F, 3'd5, 8'd0);    // threshold end
        send_exact(KIND_BYTE, 8'h5A, 32'h1234_5678, 3'd3, 8'd0);    // closed, ignored
        send_exact(KIND_TICK, 8'h00, 32'h0, 3'd1, 8'd0);
        send_exact(KIND_TICK, 8'h00, 32'h0, 3'd2, 8'd0);
        send_exact(KIND_TICK, 8'h00, 32'h0, 3'd6, 8'd0);            // second end on expiry
        send_exact(KIND_TICK, 8'h00, 32'h0, 3'd7, 8'd0);
        send_exact(KIND_READ, 8'h00, 32'h0, 3'd0, 8'd2);
        send_exact(KIND_RESTART, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'hFF);
        send_exact(KIND_READ, 8'h00, 32'h0, 3'd0, 8'd1);            // beyond length
        send_exact(KIND_BYTE, 8'h80, 32'h0, 3'd0, 8'd0);
        send_exact(KIND_BYTE, 8'h7F, 32'h0, 3'd0, 8'd0);            // zero gap
        send_exact(KIND_READ, 8'h00, 32'h0, 3'd0, 8'd1);

        configure(0, 1, 1);
        run_frames(40, 4);

        // fill the buffer past capacity with no timeout
        configure(256, 0, 255);
        send(rand_item(KIND_RESTART));
        repeat (270) send(rand_item(KIND_BYTE));
        repeat (20) send(rand_item(KIND_READ));
        repeat (5) send(rand_item(KIND_TICK));
        run_frames(20, 10);

        calm = 1'b1;
        configure($urandom_range(1, 20), $urandom_range(1, 6), $urandom_range(1, 255));
        run_frames(50, 16);
        calm = 1'b0;

        wait_drained();
        apb_write(REG_NONE, $urandom);
        configure(5, 65535, 128);
        run_frames(30, 8);

        configure($urandom_range(0, 40), $urandom_range(1, 10), $urandom_range(1, 255));
        run_frames(50, 24);

        wait_drained();
        if (tracker.errors == 0 && tracker.due_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
